FILE: sv/sbl_pkg.sv
`timescale 1ns / 1ps

package sbl_pkg;

    // Operation codes of an input item.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_DELETED  = 2'd2,
        ST_NOTFOUND = 2'd3
    } sbl_status_t;

    // One input item.
    typedef struct packed {
        logic              command;
        logic signed [7:0] value;
    } sbl_in_t;

    // One result item.
    typedef struct packed {
        sbl_status_t       status;
        logic [4:0]        count;
        logic signed [7:0] head_value;
        logic              empty_res;
    } sbl_out_t;

    // Per-operation control broadcast to every cell.
    typedef struct packed {
        logic insert;
        logic remove;
    } sbl_cell_ctrl_t;

endpackage

FILE: sv/sbl_cell.sv
`timescale 1ns / 1ps

module sbl_cell (
    input  logic                   clk,
    input  sbl_pkg::sbl_cell_ctrl_t ctrl,
    input  logic signed [7:0]      value,
    input  logic                   occupied,
    input  logic                   left_gt,
    input  logic signed [7:0]      left_entry,
    input  logic signed [7:0]      right_entry,
    output logic signed [7:0]      entry,
    output logic                   gt,
    output logic                   eq
);
    import sbl_pkg::*;

    logic signed [7:0] entry_reg;
    logic signed [7:0] entry_next;

    // Local comparison against the broadcast value.
    assign gt    = occupied && (value > entry_reg);
    assign eq    = occupied && (value == entry_reg);
    assign entry = entry_reg;

    // Cells holding smaller entries keep them; the rest shift right on an
    // insert (the boundary cell takes the new value) or left on a removal.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert && !gt)
        begin
            entry_next = left_gt ? value : left_entry;
        end
        else if (ctrl.remove && !gt)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

FILE: sv/sorted_byte_list_core.sv
`timescale 1ns / 1ps

// Sorted byte list: holds up to CAPACITY signed bytes in ascending order,
// duplicates allowed, in a row of compare-and-shift cells.
//
// Input channel: item (command, value) is taken at a rising edge where start
// is high and busy is low. Insert places the value before the first entry
// that is not smaller; delete removes the first entry equal to the value.
//
// Result channel: done is high for exactly one cycle, in the cycle after the
// item was taken, while result carries status, count, the smallest entry
// (zero when empty) and the empty flag. The receiver cannot stall; the
// result holds until the next taken item replaces it.
//
// Throughput: one item per cycle. Every cell compares and shifts in the
// same cycle, so busy stays low and start may be held high continuously.
//
// Reset: the list is empty after rst_n; no clearing pass is needed since
// only cells below the fill count are ever compared or reported.
module sorted_byte_list_core #(
    parameter int CAPACITY = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  sbl_pkg::sbl_in_t  item,
    output logic              done,
    output sbl_pkg::sbl_out_t result
);
    import sbl_pkg::*;

    localparam int FILL_W = $clog2(CAPACITY + 1);

    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              done_reg;
    sbl_status_t       status_reg;
    sbl_status_t       status_next;

    logic signed [7:0] entry_w [CAPACITY];
    logic [CAPACITY-1:0] gt_w;
    logic [CAPACITY-1:0] eq_w;

    logic           accept;
    logic           full;
    logic           found;
    sbl_cell_ctrl_t ctrl;
    logic [FILL_W+4:0] fill_ext;

    assign accept = start && !busy;
    assign busy   = 1'b0;
    assign full   = (fill_reg == FILL_W'(CAPACITY));
    assign found  = |eq_w;

    // Control broadcast: a refused insert or a missing value changes nothing.
    always_comb
    begin
        ctrl.insert = accept && (item.command == CMD_INSERT) && !full;
        ctrl.remove = accept && (item.command == CMD_REMOVE) && found;
    end

    // Row of cells; each sees its left and right neighbors.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic              occ;
        logic              lgt;
        logic signed [7:0] lent;
        logic signed [7:0] rent;

        assign occ = (FILL_W'(i) < fill_reg);

        if (i == 0)
        begin : g_first
            assign lgt  = 1'b1;
            assign lent = item.value;
        end
        else
        begin : g_mid
            assign lgt  = gt_w[i-1];
            assign lent = entry_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign rent = entry_w[i];
        end
        else
        begin : g_inner
            assign rent = entry_w[i+1];
        end

        sbl_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .value       (item.value),
            .occupied    (occ),
            .left_gt     (lgt),
            .left_entry  (lent),
            .right_entry (rent),
            .entry       (entry_w[i]),
            .gt          (gt_w[i]),
            .eq          (eq_w[i])
        );
    end

    // Fill count and status of the accepted item.
    always_comb
    begin
        fill_next   = fill_reg;
        status_next = status_reg;
        if (accept)
        begin
            if (item.command == CMD_INSERT)
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_INSERTED;
                    fill_next   = fill_reg + 1'b1;
                end
            end
            else
            begin
                if (found)
                begin
                    status_next = ST_DELETED;
                    fill_next   = fill_reg - 1'b1;
                end
                else
                begin
                    status_next = ST_NOTFOUND;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_INSERTED;
        end
        else
        begin
            fill_reg   <= fill_next;
            done_reg   <= accept;
            status_reg <= status_next;
        end
    end

    // Result fields read from the updated row; count wraps at the field width.
    assign fill_ext = {5'b0, fill_reg};
    assign done     = done_reg;

    always_comb
    begin
        result.status     = status_reg;
        result.count      = fill_ext[4:0];
        result.head_value = (fill_reg != '0) ? entry_w[0] : 8'sd0;
        result.empty_res  = (fill_reg == '0);
    end

`ifndef SYNTHESIS
    // Every accepted item yields a result in the next cycle.
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("result strobe missing after accepted item");

    // The fill count never exceeds the capacity.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(CAPACITY))
        else $error("fill count beyond capacity");

    // A full report only happens with every cell occupied and nothing moved.
    a_full_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_FULL) |->
            (fill_reg == FILL_W'(CAPACITY)) && $stable(fill_reg))
        else $error("full status with free cells");

    // A deletion shrinks the list by exactly one entry.
    a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_DELETED) |->
            (fill_reg == $past(fill_reg) - 1'b1))
        else $error("deletion did not shrink the list by one");
`endif

endmodule
